/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lfa_pkg.sv */
// ---------------------------------------------------------------------------
// lfa_pkg
// Shared constants, codes and types of the lowest free id allocator
// ---------------------------------------------------------------------------
package lfa_pkg;

  localparam int ID_SPACE  = 256;
  localparam int ID_W      = 8;
  localparam int ID_MAX    = 255;
  localparam int TOP_ID    = (ID_SPACE - 1 < ID_MAX) ? ID_SPACE - 1 : ID_MAX;
  localparam int MAP_W     = TOP_ID + 1;
  localparam int GRP_W     = 16;
  localparam int GRP_BIT_W = 4;
  // padded map: power of two with at least two groups
  localparam int PAD_W     = (MAP_W <= GRP_W) ? 2 * GRP_W : (1 << $clog2(MAP_W));
  localparam int NGRP      = PAD_W / GRP_W;
  localparam int GRP_SEL_W = $clog2(NGRP);
  localparam int IDX_W     = $clog2(PAD_W);

  localparam logic [ID_W-1:0] TOP_ID_V = ID_W'(TOP_ID);

  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_RELEASE  = 2'd1;
  localparam logic [1:0] ACT_QUERY    = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IN_USE  = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // id zero and ids past the top never count as free
  function automatic logic [PAD_W-1:0] fixed_mask();
    logic [PAD_W-1:0] m;
    for (int i = 0; i < PAD_W; i++) begin
      m[i] = (i == 0) || (i > TOP_ID);
    end
    return m;
  endfunction

  function automatic logic [NGRP-1:0] full_init();
    logic [PAD_W-1:0] m;
    logic [NGRP-1:0]  f;
    m = fixed_mask();
    for (int g = 0; g < NGRP; g++) begin
      f[g] = &m[g*GRP_W +: GRP_W];
    end
    return f;
  endfunction

  localparam logic [PAD_W-1:0] FIXED_MASK = fixed_mask();
  localparam logic [NGRP-1:0]  FULL_INIT  = full_init();

  // map after the current update, as seen by the free id search
  typedef struct packed {
    logic [PAD_W-1:0] taken;
    logic [NGRP-1:0]  grp_full;
  } map_view_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] used_count;
  } upd_res_t;

endpackage

/* rtl/lfa_map.sv */
// ---------------------------------------------------------------------------
// lfa_map
// Id usage map, per-group full flags and use count, updated once per item
// ---------------------------------------------------------------------------
module lfa_map (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  logic [1:0]               action,
  input  logic [lfa_pkg::ID_W-1:0] id,
  output lfa_pkg::map_view_t       view,
  output lfa_pkg::upd_res_t        res
);

  logic [lfa_pkg::PAD_W-1:0]     map_r, map_nxt;
  logic [lfa_pkg::NGRP-1:0]      grp_full_r, grp_full_nxt;
  logic [lfa_pkg::ID_W-1:0]      count_r, count_nxt;
  logic [lfa_pkg::PAD_W-1:0]     taken;
  logic [lfa_pkg::IDX_W-1:0]     idx;
  logic [lfa_pkg::GRP_SEL_W-1:0] grp;
  logic                          id_ok;
  logic                          cur;
  lfa_pkg::status_t              status;

  always_comb begin
    id_ok     = (id != '0) && (id <= lfa_pkg::TOP_ID_V);
    idx       = id[lfa_pkg::IDX_W-1:0];
    grp       = idx[lfa_pkg::IDX_W-1:lfa_pkg::GRP_BIT_W];
    cur       = map_r[idx];
    map_nxt   = map_r;
    count_nxt = count_r;
    status    = lfa_pkg::ST_OK;
    case (action)
      lfa_pkg::ACT_REGISTER: begin
        if (!id_ok) begin
          status = lfa_pkg::ST_INVALID;
        end else if (cur) begin
          status = lfa_pkg::ST_IN_USE;
        end else begin
          map_nxt[idx] = 1'b1;
          count_nxt    = count_r + 8'd1;
        end
      end
      lfa_pkg::ACT_RELEASE: begin
        if (!id_ok) begin
          status = lfa_pkg::ST_INVALID;
        end else if (!cur) begin
          status = lfa_pkg::ST_ABSENT;
        end else begin
          map_nxt[idx] = 1'b0;
          count_nxt    = count_r - 8'd1;
        end
      end
      default: begin
      end
    endcase
    taken = map_nxt | lfa_pkg::FIXED_MASK;
    // only the touched group can change its full flag
    grp_full_nxt      = grp_full_r;
    grp_full_nxt[grp] = &taken[{grp, {lfa_pkg::GRP_BIT_W{1'b0}}} +: lfa_pkg::GRP_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r      <= '0;
      grp_full_r <= lfa_pkg::FULL_INIT;
      count_r    <= '0;
    end else if (fire) begin
      map_r      <= map_nxt;
      grp_full_r <= grp_full_nxt;
      count_r    <= count_nxt;
    end
  end

  assign view.taken      = taken;
  assign view.grp_full   = grp_full_nxt;
  assign res.status      = status;
  assign res.used_count  = count_nxt;

endmodule

/* rtl/lfa_pick.sv */
// ---------------------------------------------------------------------------
// lfa_pick
// Two-level priority search for the lowest id not in use
// ---------------------------------------------------------------------------
module lfa_pick (
  input  lfa_pkg::map_view_t       view,
  output logic [lfa_pkg::ID_W-1:0] free_id
);

  logic [lfa_pkg::GRP_SEL_W-1:0] gsel;
  logic [lfa_pkg::GRP_BIT_W-1:0] bsel;
  logic [lfa_pkg::GRP_W-1:0]     bits;
  logic                          any;

  always_comb begin
    any  = 1'b0;
    gsel = '0;
    // first group with a clear bit
    for (int g = lfa_pkg::NGRP - 1; g >= 0; g--) begin
      if (!view.grp_full[g]) begin
        any  = 1'b1;
        gsel = g[lfa_pkg::GRP_SEL_W-1:0];
      end
    end
    bits = view.taken[{gsel, {lfa_pkg::GRP_BIT_W{1'b0}}} +: lfa_pkg::GRP_W];
    bsel = '0;
    for (int b = lfa_pkg::GRP_W - 1; b >= 0; b--) begin
      if (!bits[b]) begin
        bsel = b[lfa_pkg::GRP_BIT_W-1:0];
      end
    end
    free_id = '0;
    if (any) begin
      free_id[lfa_pkg::IDX_W-1:0] = {gsel, bsel};
    end
  end

endmodule

/* rtl/lowest_free_id_allocator.sv */
// ---------------------------------------------------------------------------
// lowest_free_id_allocator
// Set of ids in use with register, release and lowest-free query
// ---------------------------------------------------------------------------
// One item enters per clock and its result is offered from the output
// register: the item is held in an input register, then the map update and
// the lowest-free search run on it and land in the output register.
// Items take a single pass, so back-pressure on the result side is
// the only thing that slows the flow. The usable ids are 1 up to ID_SPACE-1
// (at most 255); every result gives the lowest free id after the item (0 when
// all are taken), a status and the count of ids in use.
module lowest_free_id_allocator (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_action,
  input  logic [lfa_pkg::ID_W-1:0] in_id_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [lfa_pkg::ID_W-1:0] out_free_id,
  output logic [1:0]               out_status,
  output logic [lfa_pkg::ID_W-1:0] out_used_count
);

  logic                     s1_valid_r;
  logic [1:0]               s1_action_r;
  logic [lfa_pkg::ID_W-1:0] s1_id_r;
  logic                     s1_go;

  logic                     out_valid_r;
  logic [lfa_pkg::ID_W-1:0] out_free_id_r;
  logic [1:0]               out_status_r;
  logic [lfa_pkg::ID_W-1:0] out_used_count_r;

  lfa_pkg::map_view_t       view;
  lfa_pkg::upd_res_t        res;
  logic [lfa_pkg::ID_W-1:0] free_id;
  lfa_pkg::status_t         status_nxt;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  lfa_map u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_go),
    .action (s1_action_r),
    .id     (s1_id_r),
    .view   (view),
    .res    (res)
  );

  lfa_pick u_pick (
    .view    (view),
    .free_id (free_id)
  );

  // query (and the spare code) with nothing free reports invalid
  assign status_nxt = (s1_action_r[1] && free_id == '0) ? lfa_pkg::ST_INVALID : res.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action_r <= in_action;
      s1_id_r     <= in_id_value;
    end
    if (s1_go) begin
      out_free_id_r    <= free_id;
      out_status_r     <= status_nxt;
      out_used_count_r <= res.used_count;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_free_id    = out_free_id_r;
  assign out_status     = out_status_r;
  assign out_used_count = out_used_count_r;

endmodule

/* rtl/lfa_checker.sv */
// ---------------------------------------------------------------------------
// lfa_checker
// Port-level checks of the lowest free id allocator, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lfa_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               in_action,
  input logic [lfa_pkg::ID_W-1:0] in_id_value,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [lfa_pkg::ID_W-1:0] out_free_id,
  input logic [1:0]               out_status,
  input logic [lfa_pkg::ID_W-1:0] out_used_count
);

  // after reset nothing is pending and an item can enter
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid && in_ready), "result or stall after reset")

  // no free id exactly when every usable id is counted as in use
  `ASSERT_CLK(a_full_count, out_valid |-> ((out_free_id == '0) == (out_used_count == lfa_pkg::TOP_ID_V)), "free id and count disagree")

  `ASSERT_CLK(a_free_range, out_valid |-> (out_free_id <= lfa_pkg::TOP_ID_V), "free id past the top id")

  `ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_free_id) && $stable(out_status) && $stable(out_used_count)), "stalled item changed")

endmodule

bind lowest_free_id_allocator lfa_checker u_lfa_checker (.*);

/* dv/lowest_free_id_allocator_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lowest_free_id_allocator_test
// Self-checking bench for the lowest free id allocator: a directed opening,
// random register/release/query traffic, a full fill of the id space, and
// randomly paced senders and receivers with one long output stall
// ---------------------------------------------------------------------------
module lowest_free_id_allocator_test;

  // action code the block handles as a query
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [lfa_pkg::ID_W-1:0] free_id;
    lfa_pkg::status_t         status;
    logic [lfa_pkg::ID_W-1:0] used_count;
  } alloc_result_t;

  class id_set_scoreboard;
    logic [lfa_pkg::ID_SPACE-1:0] id_taken;
    logic [lfa_pkg::ID_W-1:0]     taken_total;
    alloc_result_t                expected_q[$];
    int                           mismatches;

    function new();
      id_taken    = '0;
      taken_total = '0;
      mismatches  = 0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // apply one accepted item to the shadow id set and queue its result
    function void note_item(logic [1:0] action, logic [lfa_pkg::ID_W-1:0] id);
      alloc_result_t r;
      logic          id_ok;
      id_ok    = (id >= 1) && (int'(id) <= lfa_pkg::TOP_ID);
      r.status = lfa_pkg::ST_OK;
      case (action)
        lfa_pkg::ACT_REGISTER: begin
          if (!id_ok) r.status = lfa_pkg::ST_INVALID;
          else if (id_taken[id]) r.status = lfa_pkg::ST_IN_USE;
          else begin
            id_taken[id] = 1'b1;
            taken_total  = taken_total + 1'b1;
          end
        end
        lfa_pkg::ACT_RELEASE: begin
          if (!id_ok) r.status = lfa_pkg::ST_INVALID;
          else if (!id_taken[id]) r.status = lfa_pkg::ST_ABSENT;
          else begin
            id_taken[id] = 1'b0;
            taken_total  = taken_total - 1'b1;
          end
        end
        default: ;
      endcase
      r.free_id = '0;
      for (int i = lfa_pkg::TOP_ID; i >= 1; i--) begin
        if (!id_taken[i]) r.free_id = lfa_pkg::ID_W'(i);
      end
      if (action != lfa_pkg::ACT_REGISTER && action != lfa_pkg::ACT_RELEASE &&
          r.free_id == 0)
        r.status = lfa_pkg::ST_INVALID;
      r.used_count = taken_total;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [lfa_pkg::ID_W-1:0] free_id, logic [1:0] status,
                      logic [lfa_pkg::ID_W-1:0] used_count);
      alloc_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = expected_q.pop_front();
        if (free_id !== want.free_id)
          report_mismatch($sformatf("free_id %0d, want %0d", free_id, want.free_id));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (used_count !== want.used_count)
          report_mismatch($sformatf("used_count %0d, want %0d", used_count,
                                    want.used_count));
      end
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_action;
  logic [lfa_pkg::ID_W-1:0] in_id_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [lfa_pkg::ID_W-1:0] out_free_id;
  logic [1:0]               out_status;
  logic [lfa_pkg::ID_W-1:0] out_used_count;

  id_set_scoreboard sb = new();
  int               hold_left = 0;
  int               burst_left = 0;

  lowest_free_id_allocator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_id_value    (in_id_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_free_id    (out_free_id),
    .out_status     (out_status),
    .out_used_count (out_used_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // both handshakes are observed on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_action, in_id_value);
      if (out_valid && out_ready) sb.check_result(out_free_id, out_status, out_used_count);
    end
  end

  // receiver: changes stall mode now and then, honors long hold requests
  initial begin
    int mode;
    int mode_left;
    int tick;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        tick++;
        case (mode)
          0:       out_ready = 1'b1;
          1:       out_ready = 1'($urandom_range(0, 1));
          default: out_ready = (tick % 3 == 0);
        endcase
      end
    end
  end

  task send_item(logic [1:0] action, logic [lfa_pkg::ID_W-1:0] id);
    @(negedge clk);
    in_valid    = 1'b1;
    in_action   = action;
    in_id_value = id;
    do @(posedge clk); while (!in_ready);
  endtask

  task idle(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // bursts of random length with random gaps, some bursts run back to back
  task pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      idle(gap);
    end
    burst_left--;
  endtask

  task send_paced(logic [1:0] action, logic [lfa_pkg::ID_W-1:0] id);
    send_item(action, id);
    pace();
  endtask

  task wait_drained();
    idle(1);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task send_mixed(int count, int id_top, bit paced);
    int                       r;
    logic [1:0]               action;
    logic [lfa_pkg::ID_W-1:0] id;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 8) id = '0;
      else if (r < 75) id = lfa_pkg::ID_W'($urandom_range(1, id_top));
      else id = lfa_pkg::ID_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 45) action = lfa_pkg::ACT_REGISTER;
      else if (r < 75) action = lfa_pkg::ACT_RELEASE;
      else if (r < 93) action = lfa_pkg::ACT_QUERY;
      else action = ACT_SPARE;
      if (paced) send_paced(action, id);
      else send_item(action, id);
    end
  endtask

  initial begin
    logic [lfa_pkg::ID_W-1:0] order [lfa_pkg::TOP_ID];
    logic [lfa_pkg::ID_W-1:0] tmp;
    int                       k;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = lfa_pkg::ACT_QUERY;
    in_id_value = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed opening: empty set, bad ids, duplicates, absent releases
    send_paced(lfa_pkg::ACT_QUERY,    8'd0);
    send_paced(ACT_SPARE,             8'd0);
    send_paced(lfa_pkg::ACT_REGISTER, 8'd0);
    send_paced(lfa_pkg::ACT_RELEASE,  8'd0);
    send_paced(lfa_pkg::ACT_RELEASE,  8'd255);
    send_paced(lfa_pkg::ACT_REGISTER, 8'd255);
    send_paced(lfa_pkg::ACT_REGISTER, 8'd255);
    send_paced(lfa_pkg::ACT_REGISTER, 8'd1);
    send_paced(lfa_pkg::ACT_REGISTER, 8'd2);
    send_paced(lfa_pkg::ACT_QUERY,    8'd255);
    send_paced(lfa_pkg::ACT_RELEASE,  8'd1);
    send_paced(lfa_pkg::ACT_RELEASE,  8'd1);
    send_paced(lfa_pkg::ACT_REGISTER, 8'd170);
    send_paced(lfa_pkg::ACT_REGISTER, 8'd85);
    send_paced(lfa_pkg::ACT_RELEASE,  8'd255);
    send_paced(lfa_pkg::ACT_REGISTER, 8'd3);
    send_paced(lfa_pkg::ACT_REGISTER, 8'd1);
    send_paced(ACT_SPARE,             8'd255);
    send_paced(lfa_pkg::ACT_RELEASE,  8'd170);
    send_paced(lfa_pkg::ACT_RELEASE,  8'd85);
    send_paced(lfa_pkg::ACT_RELEASE,  8'd2);
    send_paced(lfa_pkg::ACT_RELEASE,  8'd3);
    send_paced(lfa_pkg::ACT_RELEASE,  8'd1);

    send_mixed(80, 16, 1'b1);

    // long output stall while items keep coming, so the input backs up
    wait_drained();
    hold_left = 60;
    send_mixed(30, 16, 1'b0);
    send_mixed(60, 24, 1'b1);

    // pause until every result is back, then fill the whole id space
    wait_drained();
    for (int i = 0; i < lfa_pkg::TOP_ID; i++) order[i] = lfa_pkg::ID_W'(i + 1);
    for (int i = lfa_pkg::TOP_ID - 1; i > 0; i--) begin
      k        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    // drop any ids left over from the mixed traffic first
    for (int i = 1; i <= lfa_pkg::TOP_ID; i++) begin
      if (sb.id_taken[i]) send_paced(lfa_pkg::ACT_RELEASE, lfa_pkg::ID_W'(i));
    end
    for (int i = 0; i < lfa_pkg::TOP_ID; i++) begin
      send_paced(lfa_pkg::ACT_REGISTER, order[i]);
      if ($urandom_range(0, 19) == 0) send_paced(lfa_pkg::ACT_QUERY, '0);
    end
    // every usable id taken
    send_paced(lfa_pkg::ACT_QUERY,    8'd0);
    send_paced(ACT_SPARE,             8'd77);
    send_paced(lfa_pkg::ACT_REGISTER, order[$urandom_range(0, lfa_pkg::TOP_ID - 1)]);
    send_paced(lfa_pkg::ACT_REGISTER, 8'd0);
    send_paced(lfa_pkg::ACT_RELEASE,  8'd0);
    for (int i = 0; i < 30; i++) begin
      send_paced(lfa_pkg::ACT_RELEASE, order[i]);
      if ($urandom_range(0, 4) == 0) send_paced(lfa_pkg::ACT_QUERY, '0);
    end

    send_mixed(40, 40, 1'b1);

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
